// ===== rtl/ict_pkg.sv =====
// Shared types, constant tables and register codes for the count to brightness converter.
package ict_pkg;

  localparam int COUNT_BITS_DEF     = 10;
  localparam int TEMP_FRAC_BITS_DEF = 7;
  localparam int RAW_COUNT_W        = 10;
  localparam int LOG_FRAC           = 28;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  typedef struct packed {
    logic [RAW_COUNT_W-1:0] raw_count;
    logic                   end_in;
  } ict_in_t;

  typedef struct packed {
    logic [15:0] brightness;
    logic        missing;
    logic        end_out;
  } ict_out_t;

  // Per-pixel status that travels down the pipeline beside the data.
  typedef struct packed {
    logic missing;
    logic zero;
    logic sat;
    logic pos;
    logic endf;
  } ict_flags_t;

  typedef enum logic [1:0] {
    REG_SATELLITE = 2'd0,
    REG_CHANNEL   = 2'd1,
    REG_GAIN      = 2'd2,
    REG_BIAS      = 2'd3
  } ict_reg_t;

  // Rows are satellites 8 to 12, columns are channels 2 to 5.
  localparam logic [24:0] FK1_TAB [0:4][0:3] = '{
    '{25'd19998000, 25'd3879200, 25'd973780, 25'd694450},
    '{25'd19881000, 25'd3873200, 25'd971720, 25'd689950},
    '{25'd19840000, 25'd3908600, 25'd977430, 25'd682850},
    '{25'd20018000, 25'd3878900, 25'd965340, 25'd687780},
    '{25'd20096000, 25'd4370200, 25'd968590, 25'd504710}
  };
  localparam logic [18:0] FK2_TAB [0:4][0:3] = '{
    '{19'd368420, 19'd213270, 19'd134530, 19'd120200},
    '{19'd367700, 19'd213160, 19'd134440, 19'd119940},
    '{19'd367450, 19'd213810, 19'd134700, 19'd119520},
    '{19'd368540, 19'd213270, 19'd134150, 19'd119810},
    '{19'd369020, 19'd221910, 19'd134300, 19'd108070}
  };
  localparam logic [18:0] TC1_TAB [0:4][0:3] = '{
    '{19'd63568, 19'd60603, 19'd37351, 19'd22171},
    '{19'd58637, 19'd48409, 19'd36225, 19'd20144},
    '{19'd62223, 19'd61437, 19'd27790, 19'd21145},
    '{19'd62864, 19'd59339, 19'd38284, 19'd20258},
    '{19'd69703, 19'd508315, 19'd37554, 19'd9537}
  };
  localparam logic [16:0] TC2_TAB [0:4][0:3] = '{
    '{17'd99911, 17'd99858, 17'd99873, 17'd99916},
    '{17'd99917, 17'd99887, 17'd99876, 17'd99923},
    '{17'd99912, 17'd99857, 17'd99905, 17'd99919},
    '{17'd99911, 17'd99861, 17'd99869, 17'd99923},
    '{17'd99902, 17'd98872, 17'd99872, 17'd99960}
  };

endpackage

// ===== rtl/ict_log2.sv =====
// Pipelined fixed-point log2 of a numerator and a denominator, one fraction bit per stage.
module ict_log2 import ict_pkg::*; #(
  parameter int VW = 50,
  localparam int KW = $clog2(VW)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  ict_flags_t               in_flags,
  input  logic [VW-1:0]            in_num,
  input  logic [VW-1:0]            in_den,
  output logic                     out_valid,
  output ict_flags_t               out_flags,
  output logic [KW+LOG_FRAC-1:0]   out_ln,
  output logic [KW+LOG_FRAC-1:0]   out_ld
);

  function automatic logic [KW-1:0] msb_idx(input logic [VW-1:0] v);
    logic [KW-1:0] k;
    k = '0;
    for (int i = 0; i < VW; i++) begin
      if (v[i]) k = KW'(i);
    end
    return k;
  endfunction

  function automatic logic [31:0] norm(input logic [VW-1:0] v, input logic [KW-1:0] k);
    logic [KW-1:0] amt;
    logic [VW-1:0] sh;
    amt = KW'(VW - 1) - k;
    sh  = v << amt;
    return sh[VW-1 -: 32];
  endfunction

  function automatic logic [32:0] sq_step(input logic [31:0] m);
    logic [63:0] p;
    p = 64'(m) * 64'(m);
    return p[63:31];
  endfunction

  // Stage one: leading-one position.
  logic              v1;
  ict_flags_t        f1;
  logic [VW-1:0]     num1, den1;
  logic [KW-1:0]     kn1, kd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1   <= in_flags;
      num1 <= in_num;
      den1 <= in_den;
      kn1  <= msb_idx(in_num);
      kd1  <= msb_idx(in_den);
    end
  end

  // Stage two normalizes into index 0, then each squaring stage adds one bit.
  logic [31:0]         mnr [0:LOG_FRAC];
  logic [31:0]         mdr [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] fn  [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] fd  [0:LOG_FRAC];
  logic [KW-1:0]       kn  [0:LOG_FRAC];
  logic [KW-1:0]       kd  [0:LOG_FRAC];
  logic                vld [0:LOG_FRAC];
  ict_flags_t          fl  [0:LOG_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0]  <= f1;
      mnr[0] <= norm(num1, kn1);
      mdr[0] <= norm(den1, kd1);
      fn[0]  <= '0;
      fd[0]  <= '0;
      kn[0]  <= kn1;
      kd[0]  <= kd1;
    end
  end

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
    logic [32:0] sn, sd;
    assign sn = sq_step(mnr[i]);
    assign sd = sq_step(mdr[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1]  <= fl[i];
        kn[i+1]  <= kn[i];
        kd[i+1]  <= kd[i];
        mnr[i+1] <= sn[32] ? sn[32:1] : sn[31:0];
        mdr[i+1] <= sd[32] ? sd[32:1] : sd[31:0];
        fn[i+1]  <= fn[i] | (sn[32] ? (LOG_FRAC'(1) << (LOG_FRAC - 1 - i)) : '0);
        fd[i+1]  <= fd[i] | (sd[32] ? (LOG_FRAC'(1) << (LOG_FRAC - 1 - i)) : '0);
      end
    end
  end

  assign out_valid = vld[LOG_FRAC];
  assign out_flags = fl[LOG_FRAC];
  assign out_ln    = {kn[LOG_FRAC], fn[LOG_FRAC]};
  assign out_ld    = {kd[LOG_FRAC], fd[LOG_FRAC]};

endmodule

// ===== rtl/ict_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating on overflow.
module ict_div import ict_pkg::*; #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 41,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ict_flags_t       in_flags,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_valid,
  output ict_flags_t       out_flags,
  output logic [Q_W-1:0]   out_q
);

  localparam int HW = NUM_W - Q_W;
  localparam int CW = (HW > DEN_W) ? HW : DEN_W;

  logic [CW-1:0] hi_x, den_x;
  logic          ovf0;

  assign hi_x  = CW'(in_num[NUM_W-1:Q_W]);
  assign den_x = CW'(in_den);
  // The quotient does not fit when the upper numerator bits already reach the divisor.
  assign ovf0  = hi_x >= den_x;

  logic [DEN_W-1:0] rem [0:Q_W];
  logic [Q_W-1:0]   q   [0:Q_W];
  logic [Q_W-1:0]   lo  [0:Q_W];
  logic [DEN_W-1:0] dn  [0:Q_W];
  logic             ov  [0:Q_W];
  logic             vld [0:Q_W];
  ict_flags_t       fl  [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0]  <= in_flags;
      rem[0] <= ovf0 ? '0 : DEN_W'(hi_x);
      q[0]   <= '0;
      lo[0]  <= in_num[Q_W-1:0];
      dn[0]  <= in_den;
      ov[0]  <= ovf0;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [DEN_W:0] trial, diff;
    logic           ge;
    assign trial = {rem[i], lo[i][Q_W-1-i]};
    assign diff  = trial - {1'b0, dn[i]};
    assign ge    = trial >= {1'b0, dn[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1]  <= fl[i];
        lo[i+1]  <= lo[i];
        dn[i+1]  <= dn[i];
        ov[i+1]  <= ov[i];
        rem[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q[i+1]   <= q[i] | (ge ? (Q_W'(1) << (Q_W - 1 - i)) : '0);
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_flags = fl[Q_W];
  assign out_q     = ov[Q_W] ? '1 : q[Q_W];

endmodule

// ===== rtl/ir_count_to_brightness_temp_core.sv =====
// Top level of the infrared count to brightness temperature converter.
//
// Input channel count_valid/count_stall/count_item carries one raw detector count and an
// end-of-line mark per transaction; output channel temp_valid/temp_stall/temp_item returns
// one brightness temperature (kelvin, TEMP_FRAC_BITS fraction bits) per input, in order.
// Each pixel runs through an 88-stage pipeline: radiance, a log2 unit for numerator and
// denominator with one squaring multiplier per fraction bit (28 stages), a 32-bit
// quotient divider for the inverse Planck step and a 16-bit quotient divider for the
// band correction. It accepts one pixel per cycle unless the receiver stalls a result.
// The whole pipeline advances together; when the receiver stalls a valid result, every
// stage holds and count_stall rises, so nothing is lost or repeated.
// Configuration uses wr_en/wr_index/wr_data and must be written only while the pipeline
// is empty. Reset clears all stage valid bits and loads satellite 8, channel 2,
// gain 1.0 and bias 0. A zero count yields a missing result with brightness 0.
module ir_count_to_brightness_temp_core import ict_pkg::*; #(
  parameter int COUNT_BITS     = COUNT_BITS_DEF,
  parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        count_valid,
  output logic        count_stall,
  input  ict_in_t     count_item,
  output logic        temp_valid,
  input  logic        temp_stall,
  output ict_out_t    temp_item,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [23:0] wr_data
);

  localparam int CB   = COUNT_BITS;
  localparam int NW   = CB + 18;
  localparam int DW   = CB + 24;
  localparam int PW   = 49;
  localparam int LW   = ((DW > PW) ? DW : PW) + 1;
  localparam int KW   = $clog2(LW);
  localparam int LRW  = KW + LOG_FRAC;
  localparam int DVSW = LRW + 7;
  localparam int DVW  = 17 + 16 - TEMP_FRAC_BITS;

  // Configuration registers.
  logic [3:0]         satellite;
  logic [2:0]         channel;
  logic [23:0]        gain;
  logic signed [23:0] bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      satellite <= 4'd8;
      channel   <= 3'd2;
      gain      <= 24'd65536;
      bias      <= '0;
    end else if (wr_en) begin
      case (ict_reg_t'(wr_index))
        REG_SATELLITE: satellite <= wr_data[3:0];
        REG_CHANNEL:   channel   <= wr_data[2:0];
        REG_GAIN:      gain      <= wr_data;
        REG_BIAS:      bias      <= $signed(wr_data);
        default:       ;
      endcase
    end
  end

  // Table constants, refreshed every cycle from the registers.
  logic [2:0] row;
  logic [1:0] col;

  always_comb begin
    if (satellite < 4'd8) begin
      row = 3'd0;
    end else if (satellite > 4'd12) begin
      row = 3'd4;
    end else begin
      row = 3'(satellite - 4'd8);
    end
    if (channel < 3'd2) begin
      col = 2'd0;
    end else if (channel > 3'd5) begin
      col = 2'd3;
    end else begin
      col = 2'(channel - 3'd2);
    end
  end

  logic [24:0]    k_fk1;
  logic [18:0]    k_fk2;
  logic [49:0]    k_fk2num;
  logic [34:0]    k_c1s;
  logic [DVW-1:0] k_dv;
  logic [DVW-1:0] k_half;

  always_ff @(posedge clk) begin
    k_fk1    <= FK1_TAB[row][col];
    k_fk2    <= FK2_TAB[row][col];
    k_fk2num <= 50'(k_fk2) * 50'(LOG2E_Q30);
    k_c1s    <= {TC1_TAB[row][col], 16'h0000};
    k_dv     <= DVW'(TC2_TAB[row][col]) << (16 - TEMP_FRAC_BITS);
    k_half   <= DVW'(TC2_TAB[row][col]) << (15 - TEMP_FRAC_BITS);
  end

  logic en;
  assign en          = !(temp_valid && temp_stall);
  assign count_stall = !en;

  // Stage A: Q16 count minus bias.
  logic              va;
  ict_flags_t        fa;
  logic signed [NW-1:0] na;
  logic [CB-1:0]     cnt;

  assign cnt = CB'(count_item.raw_count);

  always_ff @(posedge clk) begin
    if (en) begin
      na <= $signed({2'b00, cnt, 16'h0000}) - NW'(bias);
      fa <= '{missing: (cnt == '0), zero: 1'b0, sat: 1'b0, pos: 1'b0,
              endf: count_item.end_in};
    end
  end

  // Stage B: radiance checks, 100*N and FK1*gain.
  logic          vb;
  ict_flags_t    fb;
  logic [DW-1:0] denb;
  logic [PW-1:0] prodb;

  always_ff @(posedge clk) begin
    if (en) begin
      fb      <= '{missing: fa.missing, zero: (na <= 0) || (gain == '0), sat: fa.sat,
                   pos: fa.pos, endf: fa.endf};
      denb    <= DW'(na[NW-2:0]) * DW'(7'd100);
      prodb   <= PW'(k_fk1) * PW'(gain);
    end
  end

  // Stage C: numerator of fk1/R + 1.
  logic          vc;
  ict_flags_t    fc;
  logic [LW-1:0] numc, denc;

  always_ff @(posedge clk) begin
    if (en) begin
      fc   <= fb;
      numc <= LW'(denb) + LW'(prodb);
      denc <= LW'(denb);
    end
  end

  logic           vl;
  ict_flags_t     fl;
  logic [LRW-1:0] ln, ld;

  ict_log2 #(.VW(LW)) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vc),
    .in_flags  (fc),
    .in_num    (numc),
    .in_den    (denc),
    .out_valid (vl),
    .out_flags (fl),
    .out_ln    (ln),
    .out_ld    (ld)
  );

  // Stage D: log difference.
  logic           vd;
  ict_flags_t     fd;
  logic [LRW-1:0] dd;

  always_ff @(posedge clk) begin
    if (en) begin
      fd     <= '{missing: fl.missing, zero: fl.zero, sat: (ln <= ld), pos: fl.pos,
                  endf: fl.endf};
      dd     <= ln - ld;
    end
  end

  // Stage E: divisor 100*D.
  logic            ve;
  ict_flags_t      fe;
  logic [DVSW-1:0] dvse;

  always_ff @(posedge clk) begin
    if (en) begin
      fe   <= fd;
      dvse <= DVSW'(dd) * DVSW'(7'd100);
    end
  end

  logic       vt;
  ict_flags_t ft;
  logic [31:0] tq;

  ict_div #(.NUM_W(64), .DEN_W(DVSW), .Q_W(32)) u_div_planck (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ve),
    .in_flags  (fe),
    .in_num    ({k_fk2num, 14'h0000}),
    .in_den    (dvse),
    .out_valid (vt),
    .out_flags (ft),
    .out_q     (tq)
  );

  // Stage F: T scaled by 1e5.
  logic        vf;
  ict_flags_t  ff;
  logic [48:0] af;

  always_ff @(posedge clk) begin
    if (en) begin
      ff <= ft;
      af <= 49'(tq) * 49'(17'd100000);
    end
  end

  // Stage G: band correction numerator with half-divisor rounding.
  logic        vg;
  ict_flags_t  fg;
  logic [49:0] numg;

  always_ff @(posedge clk) begin
    if (en) begin
      fg     <= '{missing: ff.missing, zero: ff.zero, sat: ff.sat,
                  pos: (af > 49'(k_c1s)), endf: ff.endf};
      numg   <= 50'(af - 49'(k_c1s)) + 50'(k_half);
    end
  end

  logic        vq;
  ict_flags_t  fq;
  logic [15:0] bq;

  ict_div #(.NUM_W(50), .DEN_W(DVW), .Q_W(16)) u_div_band (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vg),
    .in_flags  (fg),
    .in_num    (numg),
    .in_den    (k_dv),
    .out_valid (vq),
    .out_flags (fq),
    .out_q     (bq)
  );

  // Output register.
  logic [15:0] bright;

  always_comb begin
    if (fq.missing || fq.zero) begin
      bright = '0;
    end else if (fq.sat) begin
      bright = 16'hFFFF;
    end else if (!fq.pos) begin
      bright = '0;
    end else begin
      bright = bq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_item.brightness <= bright;
      temp_item.missing    <= fq.missing;
      temp_item.end_out    <= fq.endf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va         <= 1'b0;
      vb         <= 1'b0;
      vc         <= 1'b0;
      vd         <= 1'b0;
      ve         <= 1'b0;
      vf         <= 1'b0;
      vg         <= 1'b0;
      temp_valid <= 1'b0;
    end else if (en) begin
      va         <= count_valid;
      vb         <= va;
      vc         <= vb;
      vd         <= vl;
      ve         <= vd;
      vf         <= vt;
      vg         <= vf;
      temp_valid <= vq;
    end
  end

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    temp_valid && temp_item.missing |-> temp_item.brightness == 16'h0000)
    else $error("missing pixel carries a nonzero brightness");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    count_stall == (temp_valid && temp_stall))
    else $error("input stall does not follow a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !temp_valid)
    else $error("result valid right after reset");

endmodule
